FILE: sv/tpw_pkg.sv
// ----------------------------------------------------------------------------
// tpw_pkg
// Shared widths, register indexes, sequencer states and control types for the
// transect pixel walker.
// ----------------------------------------------------------------------------
`default_nettype none

package tpw_pkg;

    // field widths
    localparam int COORD_W    = 12;
    localparam int REG_W      = 13;
    localparam int ESL_W      = 2;
    localparam int CH_W       = 4;
    localparam int ADDR_W     = 31;
    localparam int CFG_IDX_W  = 2;

    // row base (channel*rows + y) always fits in 17 bits, product in 30
    localparam int ROWB_W     = 17;
    localparam int PROD_W     = ROWB_W + REG_W;

    localparam int MAX_POINTS_DEF = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_LOG2  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_LATCH,
        S_SCAN,
        S_STEP,
        S_MUL,
        S_ADDR,
        S_OUT
    } t_state;

    // walker control
    typedef struct packed {
        logic load;
        logic step;
    } t_walk_ctl;

endpackage

`default_nettype wire

FILE: sv/tpw_walker.sv
// ----------------------------------------------------------------------------
// tpw_walker
// Grid walker: holds the current cell and the cross-multiplied error terms,
// takes one x, y or diagonal step per cycle on request.
// ----------------------------------------------------------------------------
`default_nettype none

module tpw_walker #(
    parameter int ERR_W = 20
) (
    input  wire                          i_clk,
    input  wire tpw_pkg::t_walk_ctl      i_ctl,
    input  wire [tpw_pkg::COORD_W-1:0]   i_x_start,
    input  wire [tpw_pkg::COORD_W-1:0]   i_y_start,
    input  wire [tpw_pkg::COORD_W-1:0]   i_x_end,
    input  wire [tpw_pkg::COORD_W-1:0]   i_y_end,
    output logic [tpw_pkg::COORD_W-1:0]  o_x,
    output logic [tpw_pkg::COORD_W-1:0]  o_y,
    output logic                         o_at_end
);

    logic [tpw_pkg::COORD_W-1:0] r_x, n_x;
    logic [tpw_pkg::COORD_W-1:0] r_y, n_y;
    logic [ERR_W-1:0]            r_tx, n_tx;
    logic [ERR_W-1:0]            r_ty, n_ty;
    logic [ERR_W-1:0]            r_ax2, n_ax2;
    logic [ERR_W-1:0]            r_ay2, n_ay2;
    logic                        r_x_neg, n_x_neg;
    logic                        r_y_neg, n_y_neg;

    logic [tpw_pkg::COORD_W-1:0] w_ax;
    logic [tpw_pkg::COORD_W-1:0] w_ay;
    logic                        w_do_x;
    logic                        w_do_y;

    // absolute distances for a fresh walk
    always_comb begin
        w_ax = (i_x_end > i_x_start) ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
        w_ay = (i_y_end > i_y_start) ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
    end

    // step decision: equal terms mean an exact corner, step both ways
    always_comb begin
        w_do_x = (r_tx <= r_ty);
        w_do_y = (r_tx >= r_ty);
    end

    // next walker state
    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_tx    = r_tx;
        n_ty    = r_ty;
        n_ax2   = r_ax2;
        n_ay2   = r_ay2;
        n_x_neg = r_x_neg;
        n_y_neg = r_y_neg;
        if (i_ctl.load) begin
            n_x     = i_x_start;
            n_y     = i_y_start;
            n_tx    = ERR_W'(w_ay);
            n_ty    = ERR_W'(w_ax);
            n_ax2   = ERR_W'({w_ax, 1'b0});
            n_ay2   = ERR_W'({w_ay, 1'b0});
            n_x_neg = (i_x_end < i_x_start);
            n_y_neg = (i_y_end < i_y_start);
        end else if (i_ctl.step) begin
            if (w_do_x) begin
                n_x  = r_x_neg ? (r_x - 1'b1) : (r_x + 1'b1);
                n_tx = r_tx + r_ay2;
            end
            if (w_do_y) begin
                n_y  = r_y_neg ? (r_y - 1'b1) : (r_y + 1'b1);
                n_ty = r_ty + r_ax2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_tx    <= n_tx;
        r_ty    <= n_ty;
        r_ax2   <= n_ax2;
        r_ay2   <= n_ay2;
        r_x_neg <= n_x_neg;
        r_y_neg <= n_y_neg;
    end

    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_at_end = (r_x == i_x_end) && (r_y == i_y_end);

endmodule

`default_nettype wire

FILE: sv/tpw_mul.sv
// ----------------------------------------------------------------------------
// tpw_mul
// Shared address multiplier with a registered product, used for the channel
// plane base and for each row offset.
// ----------------------------------------------------------------------------
`default_nettype none

module tpw_mul (
    input  wire                          i_clk,
    input  wire [tpw_pkg::ROWB_W-1:0]    i_a,
    input  wire [tpw_pkg::REG_W-1:0]     i_b,
    output logic [tpw_pkg::PROD_W-1:0]   o_prod
);

    logic [tpw_pkg::PROD_W-1:0] r_prod;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= tpw_pkg::PROD_W'(i_a) * tpw_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: sv/transect_pixel_walker.sv
// ----------------------------------------------------------------------------
// transect_pixel_walker
// Lists the grid cells crossed by the line between two pixel centres, with
// their band-sequential byte addresses.
// ----------------------------------------------------------------------------
// One request at a time. A request whose start equals its end gives a single
// empty_path word in the cycle after it is taken. Otherwise the walker first
// runs a counting pass over the path (up to MAX_POINTS steps) to learn whether
// it will be cut, then walks again and emits one word per cell. Each cell goes
// through a walker step, the row multiply on the shared multiplier, the address
// add and shift, and the output word, which is held while the output stalls.
// The input stalls until the final word of a path is taken.
`default_nettype none

module transect_pixel_walker #(
    parameter int MAX_POINTS = tpw_pkg::MAX_POINTS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             i_cfg_we,
    input  wire [tpw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [tpw_pkg::REG_W-1:0]        i_cfg_data,
    // request channel
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [tpw_pkg::COORD_W-1:0]      i_x_start,
    input  wire [tpw_pkg::COORD_W-1:0]      i_y_start,
    input  wire [tpw_pkg::COORD_W-1:0]      i_x_end,
    input  wire [tpw_pkg::COORD_W-1:0]      i_y_end,
    input  wire [tpw_pkg::CH_W-1:0]         i_channel,
    // cell channel
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [tpw_pkg::COORD_W-1:0]     o_x_pos,
    output logic [tpw_pkg::COORD_W-1:0]     o_y_pos,
    output logic [tpw_pkg::ADDR_W-1:0]      o_byte_address,
    output logic                            o_is_last,
    output logic                            o_truncated,
    output logic                            o_empty_path
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ERR_W = tpw_pkg::COORD_W + $clog2(2 * MAX_POINTS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    tpw_pkg::t_state r_state, n_state;

    // configuration registers
    logic [tpw_pkg::REG_W-1:0]   r_row_length;
    logic [tpw_pkg::REG_W-1:0]   r_image_rows;
    logic [tpw_pkg::ESL_W-1:0]   r_elem_log2;

    // request registers
    logic [tpw_pkg::COORD_W-1:0] r_xs, r_ys, r_xe, r_ye;
    logic [tpw_pkg::CH_W-1:0]    r_ch;
    logic [tpw_pkg::ROWB_W-1:0]  r_base;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_trunc;

    // output word
    logic                        r_out_valid;
    logic [tpw_pkg::COORD_W-1:0] r_x_pos, r_y_pos;
    logic [tpw_pkg::ADDR_W-1:0]  r_addr;
    logic                        r_last, r_trunc_o, r_empty;

    tpw_pkg::t_walk_ctl          w_ctl;
    logic [tpw_pkg::COORD_W-1:0] w_x, w_y;
    logic                        w_at_end;
    logic [tpw_pkg::ROWB_W-1:0]  w_mul_a;
    logic [tpw_pkg::REG_W-1:0]   w_mul_b;
    logic [tpw_pkg::PROD_W-1:0]  w_prod;
    logic [tpw_pkg::ADDR_W-1:0]  w_sum;
    logic [tpw_pkg::ADDR_W-1:0]  w_addr;
    logic                        w_in_acc;
    logic                        w_out_acc;
    logic                        w_scan_done;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_scan_done = w_at_end || (r_cnt == CNT_MAX);

    tpw_walker #(
        .ERR_W (ERR_W)
    ) u_walker (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_x_start (r_xs),
        .i_y_start (r_ys),
        .i_x_end   (r_xe),
        .i_y_end   (r_ye),
        .o_x       (w_x),
        .o_y       (w_y),
        .o_at_end  (w_at_end)
    );

    // multiplier operands: plane base first, then row offsets
    always_comb begin
        if (r_state == tpw_pkg::S_BASE) begin
            w_mul_a = tpw_pkg::ROWB_W'(r_ch);
            w_mul_b = r_image_rows;
        end else begin
            w_mul_a = r_base + tpw_pkg::ROWB_W'(w_y);
            w_mul_b = r_row_length;
        end
    end

    tpw_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // address add and element scaling, wraps to the address width
    always_comb begin
        w_sum  = tpw_pkg::ADDR_W'(w_prod) + tpw_pkg::ADDR_W'(w_x);
        w_addr = w_sum << r_elem_log2;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and walker control
    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            tpw_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if ((i_x_start == i_x_end) && (i_y_start == i_y_end)) begin
                        n_state = tpw_pkg::S_OUT;
                    end else begin
                        n_state = tpw_pkg::S_BASE;
                    end
                end
            end
            tpw_pkg::S_BASE: begin
                w_ctl.load = 1'b1;
                n_state    = tpw_pkg::S_LATCH;
            end
            tpw_pkg::S_LATCH: begin
                n_state = tpw_pkg::S_SCAN;
            end
            tpw_pkg::S_SCAN: begin
                if (w_scan_done) begin
                    w_ctl.load = 1'b1;
                    n_state    = tpw_pkg::S_STEP;
                end else begin
                    w_ctl.step = 1'b1;
                end
            end
            tpw_pkg::S_STEP: begin
                w_ctl.step = 1'b1;
                n_state    = tpw_pkg::S_MUL;
            end
            tpw_pkg::S_MUL: begin
                n_state = tpw_pkg::S_ADDR;
            end
            tpw_pkg::S_ADDR: begin
                n_state = tpw_pkg::S_OUT;
            end
            tpw_pkg::S_OUT: begin
                if (w_out_acc) begin
                    n_state = r_last ? tpw_pkg::S_IDLE : tpw_pkg::S_STEP;
                end
            end
            default: begin
                n_state = tpw_pkg::S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= tpw_pkg::REG_W'(1);
            r_image_rows <= tpw_pkg::REG_W'(1);
            r_elem_log2  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpw_pkg::CFG_ROW_LENGTH: r_row_length <= i_cfg_data;
                tpw_pkg::CFG_IMAGE_ROWS: r_image_rows <= i_cfg_data;
                tpw_pkg::CFG_ELEM_LOG2:  r_elem_log2  <= i_cfg_data[tpw_pkg::ESL_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture, step count and truncation flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_trunc <= 1'b0;
        end else begin
            unique case (r_state)
                tpw_pkg::S_IDLE: begin
                    r_cnt <= '0;
                end
                tpw_pkg::S_SCAN: begin
                    if (w_scan_done) begin
                        r_trunc <= !w_at_end;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                tpw_pkg::S_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_xs <= i_x_start;
            r_ys <= i_y_start;
            r_xe <= i_x_end;
            r_ye <= i_y_end;
            r_ch <= i_channel;
        end
        if (r_state == tpw_pkg::S_LATCH) begin
            r_base <= w_prod[tpw_pkg::ROWB_W-1:0];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else if (w_in_acc && (i_x_start == i_x_end) && (i_y_start == i_y_end)) begin
            r_out_valid <= 1'b1;
            r_last      <= 1'b1;
        end else if (r_state == tpw_pkg::S_ADDR) begin
            r_out_valid <= 1'b1;
            r_last      <= w_at_end || (r_cnt == CNT_MAX);
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x_pos   <= i_x_start;
            r_y_pos   <= i_y_start;
            r_addr    <= '0;
            r_trunc_o <= 1'b0;
            r_empty   <= 1'b1;
        end else if (r_state == tpw_pkg::S_ADDR) begin
            r_x_pos   <= w_x;
            r_y_pos   <= w_y;
            r_addr    <= w_addr;
            r_trunc_o <= r_trunc;
            r_empty   <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_x_pos        = r_x_pos;
    assign o_y_pos        = r_y_pos;
    assign o_byte_address = r_addr;
    assign o_is_last      = r_last;
    assign o_truncated    = r_trunc_o;
    assign o_empty_path   = r_empty;

    // checks
    a_idle_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("output word pending while taking a request");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("request taken but walker not busy");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_path) |-> (o_is_last && !o_truncated))
        else $error("empty path word not final or marked cut");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("step count beyond cap");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_is_last) |=> (r_state == tpw_pkg::S_IDLE))
        else $error("final word taken but walker still busy");

endmodule

`default_nettype wire
